FILE: rtl/core/hnm_pkg.sv
package hnm_pkg;

    localparam int DEF_TRAIN_DEPTH = 1024;
    localparam int DEF_DESC_WORDS  = 4;

    localparam int WORD_W     = 64;
    localparam int SLOT_W     = 10;
    localparam int POS_W      = 2;
    localparam int QID_W      = 16;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_DIST_W = 9;
    localparam int RATIO_W    = 9;
    localparam int COUNT_W    = 11;
    localparam int ONES_W     = 7;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd204;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;

    typedef struct packed {
        logic valid;
        logic last;
    } hnm_tag_t;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    function automatic logic [ONES_W-1:0] word_ones(input logic [WORD_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            n = n + {3'd0, byte_ones(v[i*8 +: 8])};
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/hnm_ram.sv
module hnm_ram
    import hnm_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = DEF_TRAIN_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/hnm_dist.sv
module hnm_dist
    import hnm_pkg::*;
#(
    parameter int DESC_WORDS = DEF_DESC_WORDS,
    localparam int DIST_W = $clog2(DESC_WORDS * WORD_W + 2)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  hnm_tag_t                     tag_in,
    input  logic [DESC_WORDS*WORD_W-1:0] train_words,
    input  logic [DESC_WORDS*WORD_W-1:0] query_words,
    output hnm_tag_t                     tag_out,
    output logic [DIST_W-1:0]            dist_out
);

    logic [ONES_W-1:0] ones_reg [DESC_WORDS];
    hnm_tag_t          tag1_reg;
    hnm_tag_t          tag2_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;

    // per-word popcount of the difference
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            ones_reg[w] <= word_ones(train_words[w*WORD_W +: WORD_W]
                                     ^ query_words[w*WORD_W +: WORD_W]);
        end
    end

    always_comb
    begin
        dist_next = '0;
        for (int w = 0; w < DESC_WORDS; w++)
        begin
            dist_next = dist_next + DIST_W'(ones_reg[w]);
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    assign tag_out  = tag2_reg;
    assign dist_out = dist_reg;

endmodule

FILE: rtl/core/hnm_rank.sv
module hnm_rank
    import hnm_pkg::*;
#(
    parameter int TRAIN_DEPTH = DEF_TRAIN_DEPTH,
    parameter int DESC_WORDS  = DEF_DESC_WORDS,
    localparam int AW     = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1,
    localparam int DIST_W = $clog2(DESC_WORDS * WORD_W + 2)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               arm,
    input  hnm_tag_t           tag_in,
    input  logic [DIST_W-1:0]  dist_in,
    input  logic [RATIO_W-1:0] ratio,
    output logic [DIST_W-1:0]  best_dist,
    output logic [DIST_W-1:0]  second_dist,
    output logic [AW-1:0]      best_index,
    output logic               done,
    output logic               pass
);

    localparam logic [DIST_W-1:0] NO_DIST = DIST_W'(DESC_WORDS * WORD_W + 1);
    localparam int PROD_W = RATIO_W + DIST_W + 8;

    logic [DIST_W-1:0] best_reg;
    logic [DIST_W-1:0] second_reg;
    logic [AW-1:0]     index_reg;
    logic [AW-1:0]     cnt_reg;
    logic              done_reg;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= NO_DIST;
            second_reg <= NO_DIST;
            index_reg  <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else if (arm)
        begin
            best_reg   <= NO_DIST;
            second_reg <= NO_DIST;
            index_reg  <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= tag_in.valid && tag_in.last;
            if (tag_in.valid)
            begin
                cnt_reg <= cnt_reg + AW'(1);
                // strict compares keep the earliest index on ties
                if (dist_in < best_reg)
                begin
                    second_reg <= best_reg;
                    best_reg   <= dist_in;
                    index_reg  <= cnt_reg;
                end
                else if (dist_in < second_reg)
                begin
                    second_reg <= dist_in;
                end
            end
        end
    end

    assign lhs  = {PROD_W'(best_reg)} << 8;
    assign rhs  = PROD_W'(ratio) * PROD_W'(second_reg);
    assign pass = (second_reg == NO_DIST) || (lhs <= rhs);

    assign best_dist   = best_reg;
    assign second_dist = second_reg;
    assign best_index  = index_reg;
    assign done        = done_reg;

endmodule

FILE: rtl/core/hamming_nndr_descriptor_matcher.sv
// Brute-force Hamming matcher with a nearest-neighbor distance ratio test.
// Items on the slave stream either load one 64-bit word of a train
// descriptor into the train store (tuser = 0) or deliver one word of the
// query descriptor (tuser = 1). The query word at position DESC_WORDS-1
// starts a search over train entries 0..N-1, N = min(train_count,
// TRAIN_DEPTH): the store is split into DESC_WORDS banks, so one whole entry
// is read per cycle; no further item is accepted until the search has handed
// its result to the output register, once any previous result there is taken.
// A result goes out only when best*256 <= ratio_q8*second, or when there is
// no second candidate (second_distance = DESC_WORDS*64+1); an empty train
// set gives no result. The train store has no reset: search only entries
// that were loaded. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no search runs, as the block
// itself does not enforce it.
module hamming_nndr_descriptor_matcher
    import hnm_pkg::*;
#(
    parameter int TRAIN_DEPTH = DEF_TRAIN_DEPTH,
    parameter int DESC_WORDS  = DEF_DESC_WORDS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // slot[9:0], word_pos[11:10], word_bits[75:12], query_id[91:76], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic [0:0]             s_axis_tuser,
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // match_query[15:0], match_train[25:16], best_distance[34:26],
    // second_distance[43:35], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW     = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
    localparam int WW     = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
    localparam int DIST_W = $clog2(DESC_WORDS * WORD_W + 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // input item fields
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  word_pos;
    logic [WORD_W-1:0] word_bits;
    logic [QID_W-1:0]  query_id;

    logic        accept;
    logic [31:0] pos32;
    logic [31:0] slot32;
    logic [WW-1:0] qidx;
    logic        pos_ok;
    logic        pos_last;
    logic        load_ok;
    logic        start;

    logic [RATIO_W-1:0] ratio_q8_reg;
    logic [COUNT_W-1:0] train_count_reg;
    logic [31:0]        count32;
    logic [31:0]        count_last;
    logic [AW-1:0]      last_addr;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [AW-1:0] scan_addr_reg;
    logic [QID_W-1:0] qid_reg;

    logic [WORD_W-1:0] qbuf_reg [DESC_WORDS];
    logic [DESC_WORDS-1:0] bank_we;
    logic [AW-1:0]     bank_waddr;
    logic [DESC_WORDS*WORD_W-1:0] train_words;
    logic [DESC_WORDS*WORD_W-1:0] query_words;

    hnm_tag_t          issue_tag;
    hnm_tag_t          tag_d_reg;
    hnm_tag_t          dist_tag;
    logic [DIST_W-1:0] entry_dist;

    logic [DIST_W-1:0] best_dist;
    logic [DIST_W-1:0] second_dist;
    logic [AW-1:0]     best_index;
    logic              rank_done;
    logic              rank_pass;

    logic        emit_fire;
    logic [31:0] index_ext;
    logic [31:0] best_ext;
    logic [31:0] second_ext;

    logic                  out_valid_reg;
    logic [QID_W-1:0]      out_query_reg;
    logic [OUT_IDX_W-1:0]  out_train_reg;
    logic [OUT_DIST_W-1:0] out_best_reg;
    logic [OUT_DIST_W-1:0] out_second_reg;

    // unpack the input item
    assign kind      = s_axis_tuser[0];
    assign slot      = s_axis_tdata[9:0];
    assign word_pos  = s_axis_tdata[11:10];
    assign word_bits = s_axis_tdata[75:12];
    assign query_id  = s_axis_tdata[91:76];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign pos32    = 32'(word_pos);
    assign slot32   = 32'(slot);
    assign qidx     = pos32[WW-1:0];
    assign pos_ok   = pos32 < 32'(DESC_WORDS);
    assign pos_last = pos32 == 32'(DESC_WORDS - 1);

    // drop loads outside the store and words outside the descriptor
    assign load_ok    = accept && (kind == KIND_LOAD) && pos_ok
                        && (slot32 < 32'(TRAIN_DEPTH));
    assign bank_waddr = slot32[AW-1:0];

    // saturate the search length to the store depth
    assign count32    = (32'(train_count_reg) > 32'(TRAIN_DEPTH)) ? 32'(TRAIN_DEPTH)
                                                                  : 32'(train_count_reg);
    assign count_last = count32 - 32'd1;
    assign last_addr  = count_last[AW-1:0];

    // the last query word launches a search unless the train set is empty
    assign start = accept && (kind == KIND_QUERY) && pos_last && (count32 != 32'd0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_q8_reg    <= RATIO_RESET;
            train_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RATIO: ratio_q8_reg    <= cfg_data[RATIO_W-1:0];
                REG_COUNT: train_count_reg <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // query buffer; each word feeds its own bank lane
    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_QUERY) && pos_ok)
        begin
            qbuf_reg[qidx] <= word_bits;
        end
        if (start)
        begin
            qid_reg <= query_id;
        end
    end

    // one bank per descriptor word, all read at the same entry
    for (genvar w = 0; w < DESC_WORDS; w++)
    begin : g_bank
        assign bank_we[w] = load_ok && (qidx == WW'(w));
        assign query_words[w*WORD_W +: WORD_W] = qbuf_reg[w];

        hnm_ram #(
            .WIDTH (WORD_W),
            .DEPTH (TRAIN_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[w]),
            .waddr (bank_waddr),
            .wdata (word_bits),
            .raddr (scan_addr_reg),
            .rdata (train_words[w*WORD_W +: WORD_W])
        );
    end

    // search sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (rank_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            tag_d_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tag_d_reg <= issue_tag;
            if (start)
            begin
                scan_addr_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_addr_reg <= scan_addr_reg + AW'(1);
            end
        end
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign issue_tag.valid = (state_reg == ST_SCAN);
    assign issue_tag.last  = (scan_addr_reg == last_addr);

    // tag_d_reg lines up with the registered bank read data
    hnm_dist #(
        .DESC_WORDS (DESC_WORDS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag_in      (tag_d_reg),
        .train_words (train_words),
        .query_words (query_words),
        .tag_out     (dist_tag),
        .dist_out    (entry_dist)
    );

    hnm_rank #(
        .TRAIN_DEPTH (TRAIN_DEPTH),
        .DESC_WORDS  (DESC_WORDS)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .arm         (start),
        .tag_in      (dist_tag),
        .dist_in     (entry_dist),
        .ratio       (ratio_q8_reg),
        .best_dist   (best_dist),
        .second_dist (second_dist),
        .best_index  (best_index),
        .done        (rank_done),
        .pass        (rank_pass)
    );

    // hold the search result until the output register is free
    assign emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);
    assign index_ext  = 32'(best_index);
    assign best_ext   = 32'(best_dist);
    assign second_ext = 32'(second_dist);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= rank_pass;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire && rank_pass)
        begin
            out_query_reg  <= qid_reg;
            out_train_reg  <= index_ext[OUT_IDX_W-1:0];
            out_best_reg   <= best_ext[OUT_DIST_W-1:0];
            out_second_reg <= second_ext[OUT_DIST_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_second_reg, out_best_reg, out_train_reg, out_query_reg};

    // loads never collide with a search read
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_we != '0) |-> (state_reg == ST_IDLE))
        else $error("train store written during a search");

    // distances arrive only while a search drains through the pipeline
    a_dist_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        dist_tag.valid |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("distance outside a search");

    // ranking keeps best at or below second
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        rank_done |-> (best_dist <= second_dist))
        else $error("best distance above second distance");

    // a free output register releases the result at once
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !out_valid_reg) |=> (state_reg == ST_IDLE))
        else $error("result held with a free output register");

endmodule
